FILE: hdl/lzwc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lzwc_pkg: shared constants for the lzw compressor
// widths, code limits and the hash function
// ---------------------------------------------------------------------------
package lzwc_pkg;
   localparam int MaxCodeBits = 12;
   localparam int HashBuckets = 8192;
   localparam int HashBits    = $clog2(HashBuckets);
   localparam int FirstCode   = 256;
   localparam int StartWidth  = 9;
   localparam int DictSize    = (1 << MaxCodeBits) - FirstCode;
   localparam int SlotBits    = $clog2(DictSize);
   localparam int FreeBits    = MaxCodeBits + 1;
   localparam int WidthBits   = $clog2(MaxCodeBits + 1);
   localparam int BufCells    = 8;   // byte cells in the packing chain
   localparam int CellBits    = $clog2(BufCells + 1);

   typedef logic [MaxCodeBits-1:0] code_type;

   function automatic logic [HashBits-1:0] bucket_of(input code_type prefix,
                                                      input logic [7:0] b);
      logic [31:0] h;
      h = (32'(b) << 5) ^ 32'(prefix);
      return h[HashBits-1:0];
   endfunction
endpackage
`default_nettype wire

FILE: hdl/lzwc_byte_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lzwc_byte_cell: one byte of the packing chain
// holds a byte and its end mark, shifts toward the output on demand
// ---------------------------------------------------------------------------
module lzwc_byte_cell (
   input  wire logic       clock,
   input  wire logic       shift,       // take neighbour's contents
   input  wire logic [7:0] nb_byte,
   input  wire logic       nb_mark,
   input  wire logic       load,        // or-in new bits (after shift)
   input  wire logic [7:0] load_bits,
   input  wire logic       set_mark,
   input  wire logic       clear,
   output logic      [7:0] byte_q,
   output logic            mark_q
);
   logic [7:0] byte_ff, byte_in;
   logic       mark_ff, mark_in;

   always_comb begin
      byte_in = shift ? nb_byte : byte_ff;
      mark_in = shift ? nb_mark : mark_ff;
      if (clear) begin
         byte_in = '0;
         mark_in = 1'b0;
      end
      if (load) byte_in = byte_in | load_bits;
      if (set_mark) mark_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      mark_ff <= mark_in;
   end

   assign byte_q = byte_ff;
   assign mark_q = mark_ff;
endmodule
`default_nettype wire

FILE: hdl/lzw_variable_width_compressor.sv
`timescale 1ns / 1ps
`default_nettype none
// sequential: a transaction reads its bucket head, walks the hash chain one entry at a time and,
// on a miss, emits the prefix code and adds an entry; then it gives up to three packed bytes
// before the next transaction is taken; the first byte of a stream only becomes the prefix,
// and the end of input emits the final code, padded to a whole byte
// reset: a clearing pass writes the 8192 bucket heads, one a cycle, before the first
// transaction is taken; later streams flip an epoch bit instead of clearing
// ---------------------------------------------------------------------------
// lzw_variable_width_compressor: lzw compressor, variable code width
// hash-chain dictionary and an lsb-first byte packing chain of cells
// ---------------------------------------------------------------------------
module lzw_variable_width_compressor (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_end_of_input,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic      [7:0] rsp_packed_byte,
   output logic            rsp_end_of_output
);
   localparam int MCB = lzwc_pkg::MaxCodeBits;
   localparam int HB  = lzwc_pkg::HashBits;
   localparam int SB  = lzwc_pkg::SlotBits;
   localparam int FB  = lzwc_pkg::FreeBits;
   localparam int WB  = lzwc_pkg::WidthBits;
   localparam int NC  = lzwc_pkg::BufCells;
   localparam int CB  = lzwc_pkg::CellBits;

   // controller states
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_HEAD  = 4'd2;  // bucket head read issued
   localparam logic [3:0] S_HWAIT = 4'd3;
   localparam logic [3:0] S_ENT   = 4'd4;  // entry read issued
   localparam logic [3:0] S_EWAIT = 4'd5;
   localparam logic [3:0] S_MISS  = 4'd6;  // emit prefix code, add entry if not full
   localparam logic [3:0] S_LAST  = 4'd7;  // emit final code, pad
   localparam logic [3:0] S_DRAIN = 4'd8;  // give up to three bytes

   // dictionary memories
   logic [MCB-1:0] pre_mem [lzwc_pkg::DictSize];
   logic [7:0]     suf_mem [lzwc_pkg::DictSize];
   logic [MCB-1:0] chn_mem [lzwc_pkg::DictSize];
   // bucket heads carry an epoch bit so a new stream needs no clearing pass;
   // a head left from two streams back only leads into chains of other buckets,
   // so a lookup still finds exactly the entries of the current stream
   logic [MCB:0]   head_mem [lzwc_pkg::HashBuckets];

   logic [3:0]     state_ff, state_in;
   logic [HB-1:0]  clr_ff, clr_in;
   logic           epoch_ff, epoch_in;
   logic [MCB-1:0] cur_ff, cur_in;
   logic           have_ff, have_in;
   logic [FB-1:0]  free_ff, free_in;
   logic [WB-1:0]  width_ff, width_in;
   logic [7:0]     byte_ff, byte_in;
   logic           last_ff, last_in;
   logic [HB-1:0]  hash_ff, hash_in;
   logic [MCB-1:0] code_ff, code_in;   // chain walk position
   logic [1:0]     given_ff, given_in; // bytes given this transaction
   logic           rsp_ff, rsp_in;
   logic [CB-1:0]  fill_ff, fill_in;   // whole bytes in chain
   logic [2:0]     part_ff, part_in;   // bits in partial byte

   // memory ports
   logic           head_we;
   logic [HB-1:0]  head_addr;
   logic [MCB:0]   head_wd, head_rd_ff;
   logic           ent_we;
   logic [SB-1:0]  ent_addr;
   logic [MCB-1:0] pre_rd_ff, chn_rd_ff, ent_chain_wd;
   logic [7:0]     suf_rd_ff;

   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_addr] <= head_wd;
      head_rd_ff <= head_mem[head_addr];
      if (ent_we) begin
         pre_mem[ent_addr] <= cur_ff;
         suf_mem[ent_addr] <= byte_ff;
         chn_mem[ent_addr] <= ent_chain_wd;
      end
      pre_rd_ff <= pre_mem[ent_addr];
      suf_rd_ff <= suf_mem[ent_addr];
      chn_rd_ff <= chn_mem[ent_addr];
   end

   // head value seen as a code (stale epoch reads as empty)
   logic [MCB-1:0] head_code;
   assign head_code = (head_rd_ff[MCB] == epoch_ff) ? head_rd_ff[MCB-1:0] : '0;

   // packing chain
   logic [7:0] cb_q [NC];
   logic       cm_q [NC];
   logic       c_shift, c_put, c_pad;
   logic [MCB-1:0] put_code;
   logic [NC*8-1:0] put_bits;
   logic [CB-1:0]  pad_idx;
   logic [CB+3-1:0] bitpos;

   assign bitpos   = {fill_ff, part_ff};
   assign put_bits = (NC*8)'(put_code) << bitpos;

   for (genvar i = 0; i < NC; i++) begin : g_cell
      logic [7:0] nb_b;
      logic       nb_m;
      logic [7:0] lb;
      logic [CB-1:0] tgt;
      if (i == NC - 1) begin : g_end
         assign nb_b = '0;
         assign nb_m = 1'b0;
      end else begin : g_mid
         assign nb_b = cb_q[i+1];
         assign nb_m = cm_q[i+1];
      end
      // bits land at buffer position before shift when no shift coincides
      assign lb  = put_bits[i*8 +: 8];
      assign tgt = CB'(i);
      lzwc_byte_cell u_cell (
         .clock     (clock),
         .shift     (c_shift),
         .nb_byte   (nb_b),
         .nb_mark   (nb_m),
         .load      (c_put),
         .load_bits (lb),
         .set_mark  (c_pad && pad_idx == tgt),
         .clear     (reset),
         .byte_q    (cb_q[i]),
         .mark_q    (cm_q[i])
      );
   end

   logic [FB-1:0] width_max;
   assign width_max = FB'((1 << width_ff) - 1);

   always_comb begin
      state_in = state_ff;   clr_in = clr_ff;    epoch_in = epoch_ff;
      cur_in = cur_ff;       have_in = have_ff;  free_in = free_ff;
      width_in = width_ff;   byte_in = byte_ff;  last_in = last_ff;
      hash_in = hash_ff;     code_in = code_ff;  given_in = given_ff;
      rsp_in = rsp_ff;       fill_in = fill_ff;  part_in = part_ff;
      head_we = 1'b0; head_addr = hash_ff; head_wd = '0;
      ent_we = 1'b0;  ent_addr = SB'(code_ff - MCB'(lzwc_pkg::FirstCode));
      ent_chain_wd = head_code;
      c_shift = 1'b0; c_put = 1'b0; c_pad = 1'b0;
      put_code = cur_ff; pad_idx = '0;
      req_ready = 1'b0;

      // output handshake: one byte leaves, chain shifts
      if (rsp_ff && rsp_ready) begin
         c_shift  = 1'b1;
         fill_in  = fill_ff - CB'(1);
         rsp_in   = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            head_addr = clr_ff; head_we = 1'b1; head_wd = '0;
            clr_in = clr_ff + HB'(1);
            if (clr_ff == HB'(lzwc_pkg::HashBuckets - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = !rsp_ff;
            if (req_valid && !rsp_ff) begin
               byte_in = req_data_byte; last_in = req_end_of_input;
               given_in = '0;
               if (!have_ff) begin
                  cur_in = MCB'(req_data_byte); have_in = 1'b1;
                  state_in = req_end_of_input ? S_LAST : S_DRAIN;
               end else begin
                  hash_in = lzwc_pkg::bucket_of(cur_ff, req_data_byte);
                  state_in = S_HEAD;
               end
            end
         end
         S_HEAD: state_in = S_HWAIT;
         S_HWAIT: begin
            code_in = head_code;
            state_in = S_ENT;
            if (!(head_code >= MCB'(lzwc_pkg::FirstCode) &&
                  FB'(head_code) < free_ff)) state_in = S_MISS;
         end
         S_ENT: state_in = S_EWAIT;
         S_EWAIT: begin
            if (pre_rd_ff == cur_ff && suf_rd_ff == byte_ff) begin
               cur_in = code_ff;
               state_in = last_ff ? S_LAST : S_DRAIN;
            end else if (chn_rd_ff >= code_ff ||
                         !(chn_rd_ff >= MCB'(lzwc_pkg::FirstCode)
                         && FB'(chn_rd_ff) < free_ff)) begin
               state_in = S_MISS;
            end else begin
               code_in = chn_rd_ff; state_in = S_ENT;
            end
         end
         S_MISS: begin
            // head_rd_ff still holds bucket head of hash_ff
            if (!rsp_ff) begin
               c_put = 1'b1; put_code = cur_ff;
               {fill_in, part_in} = bitpos + (CB+3)'(width_ff);
               if (free_ff < FB'(1 << MCB)) begin
                  ent_we = 1'b1;
                  ent_addr = SB'(free_ff - FB'(lzwc_pkg::FirstCode));
                  head_we = 1'b1; head_wd = {epoch_ff, free_ff[MCB-1:0]};
                  free_in = free_ff + FB'(1);
                  if (width_ff < WB'(MCB) && free_ff + FB'(1) > width_max)
                     width_in = width_ff + WB'(1);
               end
               cur_in = MCB'(byte_ff);
               state_in = last_ff ? S_LAST : S_DRAIN;
            end
         end
         S_LAST: begin
            if (!rsp_ff) begin
               c_put = 1'b1; put_code = cur_ff;
               {fill_in, part_in} = bitpos + (CB+3)'(width_ff) + (CB+3)'(7);
               part_in = '0;
               pad_idx = fill_in - CB'(1);
               c_pad = (fill_in != '0);
               epoch_in = !epoch_ff;
               free_in = FB'(lzwc_pkg::FirstCode);
               width_in = WB'(lzwc_pkg::StartWidth);
               cur_in = '0; have_in = 1'b0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!rsp_ff || rsp_ready) begin
               if (given_ff == 2'd3 || fill_in == '0) state_in = S_IDLE;
               else begin
                  rsp_in = 1'b1; given_in = given_ff + 2'd1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; epoch_ff <= 1'b1;
         cur_ff <= '0; have_ff <= 1'b0;
         free_ff <= FB'(lzwc_pkg::FirstCode);
         width_ff <= WB'(lzwc_pkg::StartWidth);
         given_ff <= '0; rsp_ff <= 1'b0; fill_ff <= '0; part_ff <= '0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; epoch_ff <= epoch_in;
         cur_ff <= cur_in; have_ff <= have_in; free_ff <= free_in;
         width_ff <= width_in; given_ff <= given_in; rsp_ff <= rsp_in;
         fill_ff <= fill_in; part_ff <= part_in;
      end
      byte_ff <= byte_in; last_ff <= last_in; hash_ff <= hash_in;
      code_ff <= code_in;
   end

   assign rsp_valid         = rsp_ff;
   assign rsp_packed_byte   = cb_q[0];
   assign rsp_end_of_output = cm_q[0];
endmodule
`default_nettype wire
